// ===== hw/rtl/accel_window_activity_classifier_unit_assert.svh =====
// Assertion macros used by the controller of the activity classifier RTL.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef ACCEL_WINDOW_ACTIVITY_CLASSIFIER_UNIT_ASSERT_SVH
`define ACCEL_WINDOW_ACTIVITY_CLASSIFIER_UNIT_ASSERT_SVH

// Condition must never hold outside reset
`define AWAC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define AWAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define AWAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/awac_pkg.sv =====
// Shared types and constants of the activity classifier.
// No dependencies; used by awac_ctrl, awac_dp and the top level.
`default_nettype none
package awac_pkg;

  localparam int WINDOW_DEF      = 200;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int NUM_REGS        = 8;
  localparam int VAR_REG_W       = 30;
  localparam int RNG_REG_W       = 16;

  localparam int STEP_LIMIT      = 409;
  localparam int RANGE_MIN_START = 40960;
  localparam int MOUSE_STEPS     = 20;
  localparam int WALK_STEPS      = 100;

  // Register indexes
  localparam logic [2:0] REG_IDLE_VAR    = 3'd0;
  localparam logic [2:0] REG_TYPING_VAR  = 3'd1;
  localparam logic [2:0] REG_MOUSE_VAR   = 3'd2;
  localparam logic [2:0] REG_STRETCH_VAR = 3'd3;
  localparam logic [2:0] REG_WALK_VAR    = 3'd4;
  localparam logic [2:0] REG_IDLE_RNG    = 3'd5;
  localparam logic [2:0] REG_TYPING_RNG  = 3'd6;
  localparam logic [2:0] REG_STRETCH_RNG = 3'd7;

  localparam logic [29:0] IDLE_VAR_RST    = 30'd16777;
  localparam logic [29:0] TYPING_VAR_RST  = 30'd83886;
  localparam logic [29:0] MOUSE_VAR_RST   = 30'd335544;
  localparam logic [29:0] STRETCH_VAR_RST = 30'd1677722;
  localparam logic [29:0] WALK_VAR_RST    = 30'd5033165;
  localparam logic [15:0] IDLE_RNG_RST    = 16'd82;
  localparam logic [15:0] TYPING_RNG_RST  = 16'd410;
  localparam logic [15:0] STRETCH_RNG_RST = 16'd614;

  // Activity codes
  localparam logic [2:0] ACT_IDLE    = 3'd0;
  localparam logic [2:0] ACT_TYPING  = 3'd1;
  localparam logic [2:0] ACT_MOUSE   = 3'd2;
  localparam logic [2:0] ACT_PHONE   = 3'd3;
  localparam logic [2:0] ACT_STRETCH = 3'd4;
  localparam logic [2:0] ACT_WALK    = 3'd5;

  // Confidence values
  localparam logic [6:0] CONF_RESET   = 7'd80;
  localparam logic [6:0] CONF_IDLE    = 7'd85;
  localparam logic [6:0] CONF_TYPING  = 7'd75;
  localparam logic [6:0] CONF_MOUSE   = 7'd70;
  localparam logic [6:0] CONF_STRETCH = 7'd65;
  localparam logic [6:0] CONF_WALK    = 7'd80;
  localparam logic [6:0] CONF_PHONE   = 7'd60;
  localparam logic [6:0] CONF_OTHER   = 7'd50;

  localparam logic CMD_STORE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [29:0] idle_var;
    logic [29:0] typing_var;
    logic [29:0] mouse_var;
    logic [29:0] stretch_var;
    logic [29:0] walk_var;
    logic [15:0] idle_rng;
    logic [15:0] typing_rng;
    logic [15:0] stretch_rng;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_sample;
    logic sqrt_step;
    logic write_mag;
    logic walk_start;
    logic walk_step;
    logic mul1;
    logic mul2;
    logic load_out;
    logic short_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic sqrt_last;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/awac_dp.sv =====
// Datapath of the activity classifier: square root unit, magnitude memory,
// window statistics, variance compare, cascade and output register. Uses awac_pkg.
`default_nettype none
module awac_dp import awac_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire cfg_t        cfg,
  input  wire logic [47:0] sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_act,
  output logic [6:0]       out_conf
);

  localparam int MAGW  = SAMPLE_BITS + 1;
  localparam int SQW   = 2 * MAGW;
  localparam int LW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AW    = LW;
  localparam int SUMW  = MAGW + LW;
  localparam int SQSW  = 2 * MAGW + LW;
  localparam int NUMW  = 2 * MAGW + 2 * LW;
  localparam int DIVISOR = WINDOW * WINDOW;
  localparam int DW    = $clog2(DIVISOR) + 1;
  localparam int TW    = VAR_REG_W + DW;
  localparam int CW    = (NUMW > TW) ? NUMW : TW;
  localparam int RNGW  = (MAGW > 17) ? MAGW : 17;
  localparam int STW   = $clog2(WINDOW + 1);
  localparam int SQCW  = $clog2(MAGW + 1);

  // Absolute value of a SAMPLE_BITS two's complement field
  function automatic logic [MAGW-1:0] abs_s(input logic [15:0] f);
    logic [23:0] ext;
    logic [MAGW-1:0] v;
    ext = 24'(f);
    v = {1'b0, ext[SAMPLE_BITS-1:0]};
    if (ext[SAMPLE_BITS-1]) abs_s = MAGW'(1 << SAMPLE_BITS) - v;
    else abs_s = v;
  endfunction

  logic [MAGW-1:0] ax, ay, az;
  logic [SQW-1:0]  sq_in;
  assign ax = abs_s(sample[15:0]);
  assign ay = abs_s(sample[31:16]);
  assign az = abs_s(sample[47:32]);
  assign sq_in = SQW'(ax * ax) + SQW'(ay * ay) + SQW'(az * az);

  // Square root, two radicand bits per step
  logic [SQW-1:0]  sq_n;
  logic [MAGW+1:0] sq_rem;
  logic [MAGW-1:0] sq_root;
  logic [SQCW-1:0] sq_cnt;
  logic [MAGW+1:0] sq_r, sq_trial;
  assign sq_r = {sq_rem[MAGW-1:0], sq_n[SQW-1:SQW-2]};
  assign sq_trial = {sq_root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sq_n <= sq_in;
      sq_rem <= '0;
      sq_root <= '0;
      sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      sq_n <= {sq_n[SQW-3:0], 2'b00};
      sq_cnt <= sq_cnt + 1'b1;
      if (sq_r >= sq_trial) begin
        sq_rem <= sq_r - sq_trial;
        sq_root <= {sq_root[MAGW-2:0], 1'b1};
      end else begin
        sq_rem <= sq_r;
        sq_root <= {sq_root[MAGW-2:0], 1'b0};
      end
    end
  end
  assign stat.sqrt_last = (sq_cnt == SQCW'(MAGW - 1));

  // Magnitude memory and write pointer
  logic [MAGW-1:0] mem [WINDOW];
  logic [AW-1:0]   wslot;
  logic            full;
  logic [AW-1:0]   rd_addr;
  logic [MAGW-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.write_mag) mem[wslot] <= sq_root;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wslot <= '0;
      full <= 1'b0;
    end else if (cmd.write_mag) begin
      if (wslot == AW'(WINDOW - 1)) begin
        wslot <= '0;
        full <= 1'b1;
      end else begin
        wslot <= wslot + 1'b1;
      end
    end
  end
  assign stat.full = full;

  // Window walk: read, square, accumulate
  logic            issuing, v1, v2, f1, f2, no_prev;
  logic [MAGW-1:0] d2, prev;
  logic [2*MAGW-1:0] sq2;
  logic [SUMW-1:0] sum;
  logic [SQSW-1:0] sumsq;
  logic [MAGW-1:0] maxv;
  logic [RNGW-1:0] minv;
  logic [STW-1:0]  steps;
  logic [MAGW-1:0] diff;
  assign diff = (d2 > prev) ? (d2 - prev) : (prev - d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.walk_step && issuing;
      v2 <= v1;
      if (cmd.walk_start) begin
        issuing <= 1'b1;
      end else if (cmd.walk_step && issuing && rd_addr == AW'(WINDOW - 1)) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    f1 <= (rd_addr == '0);
    f2 <= f1;
    sq2 <= rd_data * rd_data;
    d2 <= rd_data;
    if (cmd.walk_start) begin
      rd_addr <= '0;
      sum <= '0;
      sumsq <= '0;
      maxv <= '0;
      minv <= RNGW'(RANGE_MIN_START);
      steps <= '0;
      no_prev <= 1'b1;
    end else begin
      if (cmd.walk_step && issuing && rd_addr != AW'(WINDOW - 1)) rd_addr <= rd_addr + 1'b1;
      if (v2) begin
        sum <= sum + SUMW'(d2);
        sumsq <= sumsq + SQSW'(sq2);
        if (d2 > maxv) maxv <= d2;
        if (RNGW'(d2) < minv) minv <= RNGW'(d2);
        if (!f2 && !no_prev && diff > MAGW'(STEP_LIMIT)) steps <= steps + 1'b1;
        prev <= d2;
        no_prev <= 1'b0;
      end
    end
  end
  assign stat.walk_done = !issuing && !v1 && !v2;

  // Variance numerator W*sumsq - sum^2; thresholds scaled by W^2 so that
  // floor(num / W^2) < T becomes num < T*W^2 and > T becomes num >= (T+1)*W^2
  logic [NUMW-1:0] prod_a, prod_b, num;
  logic [TW-1:0]   thr_idle, thr_typ, thr_mouse, thr_str, thr_walk;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_a <= NUMW'(sumsq) * NUMW'(WINDOW);
      prod_b <= NUMW'(sum) * NUMW'(sum);
      thr_idle  <= TW'(cfg.idle_var) * TW'(DIVISOR);
      thr_typ   <= TW'(cfg.typing_var) * TW'(DIVISOR);
      thr_mouse <= TW'(cfg.mouse_var) * TW'(DIVISOR);
      thr_str   <= TW'(cfg.stretch_var) * TW'(DIVISOR);
      thr_walk  <= TW'(cfg.walk_var) * TW'(DIVISOR) + TW'(DIVISOR);
    end
    if (cmd.mul2) num <= prod_a - prod_b;
  end

  // Range with a wrap flag; minv starts at RANGE_MIN_START when the walk begins
  logic            rng_neg;
  logic [RNGW-1:0] rng;
  assign {rng_neg, rng} = {1'b0, RNGW'(maxv)} - {1'b0, minv};

  function automatic logic rng_lt(input logic neg, input logic [RNGW-1:0] r,
                                  input logic [15:0] lim);
    rng_lt = !neg && (r < RNGW'(lim));
  endfunction

  logic [31:0] steps32;
  logic v_idle, v_typ, v_mouse, v_str, v_walk;
  logic [2:0] act;
  logic [6:0] conf;
  assign steps32 = 32'(steps);
  assign v_idle  = CW'(num) < CW'(thr_idle);
  assign v_typ   = CW'(num) < CW'(thr_typ);
  assign v_mouse = CW'(num) < CW'(thr_mouse);
  assign v_str   = CW'(num) < CW'(thr_str);
  assign v_walk  = CW'(num) >= CW'(thr_walk);

  // Threshold cascade, first match wins
  always_comb begin
    if (v_idle && rng_lt(rng_neg, rng, cfg.idle_rng)) begin
      act = ACT_IDLE;    conf = CONF_IDLE;
    end else if (v_typ && rng_lt(rng_neg, rng, cfg.typing_rng)) begin
      act = ACT_TYPING;  conf = CONF_TYPING;
    end else if (v_mouse && steps32 > 32'(MOUSE_STEPS)) begin
      act = ACT_MOUSE;   conf = CONF_MOUSE;
    end else if ((rng_neg || rng > RNGW'(cfg.stretch_rng)) && v_str) begin
      act = ACT_STRETCH; conf = CONF_STRETCH;
    end else if (steps32 > 32'(WALK_STEPS) && v_walk) begin
      act = ACT_WALK;    conf = CONF_WALK;
    end else if (v_typ) begin
      act = ACT_PHONE;   conf = CONF_PHONE;
    end else begin
      act = ACT_IDLE;    conf = CONF_OTHER;
    end
  end

  // Output register and last confidence
  logic [6:0] last_conf;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_conf <= CONF_RESET;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (!cmd.short_out) last_conf <= conf;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_act  <= cmd.short_out ? ACT_IDLE : act;
      out_conf <= cmd.short_out ? last_conf : conf;
    end
  end
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/awac_ctrl.sv =====
// Sequencing controller of the activity classifier.
// Uses awac_pkg and the assertion macro header.
`default_nettype none
`include "accel_window_activity_classifier_unit_assert.svh"
module awac_ctrl import awac_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_cmd,
  output logic          in_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_WRITE, S_WALK, S_MUL1, S_MUL2, S_EMIT
  } state_t;

  state_t state;
  logic   short_res;
  logic   acc;

  assign in_ready = (state == S_IDLE);
  assign acc = in_valid && in_ready;

  // Decode commands from state and the accepted input
  always_comb begin
    cmd = '0;
    cmd.load_sample = acc && in_cmd == CMD_STORE;
    cmd.walk_start  = acc && in_cmd == CMD_CLASSIFY && stat.full;
    cmd.sqrt_step   = (state == S_SQRT);
    cmd.write_mag   = (state == S_WRITE);
    cmd.walk_step   = (state == S_WALK);
    cmd.mul1        = (state == S_MUL1);
    cmd.mul2        = (state == S_MUL2);
    cmd.load_out    = (state == S_EMIT) && stat.out_free;
    cmd.short_out   = short_res;
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      short_res <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (in_cmd == CMD_STORE) begin
              state <= S_SQRT;
            end else if (stat.full) begin
              state <= S_WALK;
              short_res <= 1'b0;
            end else begin
              state <= S_EMIT;
              short_res <= 1'b1;
            end
          end
        end
        S_SQRT:  if (stat.sqrt_last) state <= S_WRITE;
        S_WRITE: state <= S_IDLE;
        S_WALK:  if (stat.walk_done) state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_EMIT;
        S_EMIT:  if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `AWAC_ASSERT_NEXT(a_one_at_a_time, acc, !in_ready, "item accepted while busy")
  `AWAC_ASSERT_IMP(a_walk_full, cmd.walk_start, stat.full, "walk on partial window")
  `AWAC_ASSERT_NEVER(a_load_busy, cmd.load_out && !stat.out_free, "output overwritten")

endmodule
`default_nettype wire

// ===== hw/rtl/accel_window_activity_classifier_unit.sv =====
// Top level of the activity classifier: configuration registers, controller
// and datapath. Uses awac_pkg, awac_ctrl and awac_dp.
//
// The length of a store transaction is set by the two-bits-per-cycle square
// root unit. A classify transaction on a full window takes the accept state,
// the window walk, the MUL1 and MUL2 multiply states and the output state;
// the variance is never divided out, the thresholds are scaled by WINDOW^2
// instead. On a window not yet full a classify goes from the accept state
// straight to the output state, which stretches while the previous result
// still waits. One item is in work at a time; a result waits in the output
// register while the next item is taken. Registers sit at byte address
// 4*index on the APB port.
`default_nettype none
module accel_window_activity_classifier_unit import awac_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // sample_x[15:0], sample_y[31:16], sample_z[47:32]
  input  wire logic        s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // activity[2:0], confidence[9:3], zero[15:10]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] ridx;
  logic [2:0] act;
  logic [6:0] conf;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_var    <= IDLE_VAR_RST;
      cfg.typing_var  <= TYPING_VAR_RST;
      cfg.mouse_var   <= MOUSE_VAR_RST;
      cfg.stretch_var <= STRETCH_VAR_RST;
      cfg.walk_var    <= WALK_VAR_RST;
      cfg.idle_rng    <= IDLE_RNG_RST;
      cfg.typing_rng  <= TYPING_RNG_RST;
      cfg.stretch_rng <= STRETCH_RNG_RST;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_IDLE_VAR:    cfg.idle_var    <= pwdata[29:0];
        REG_TYPING_VAR:  cfg.typing_var  <= pwdata[29:0];
        REG_MOUSE_VAR:   cfg.mouse_var   <= pwdata[29:0];
        REG_STRETCH_VAR: cfg.stretch_var <= pwdata[29:0];
        REG_WALK_VAR:    cfg.walk_var    <= pwdata[29:0];
        REG_IDLE_RNG:    cfg.idle_rng    <= pwdata[15:0];
        REG_TYPING_RNG:  cfg.typing_rng  <= pwdata[15:0];
        REG_STRETCH_RNG: cfg.stretch_rng <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (ridx)
      REG_IDLE_VAR:    prdata = 32'(cfg.idle_var);
      REG_TYPING_VAR:  prdata = 32'(cfg.typing_var);
      REG_MOUSE_VAR:   prdata = 32'(cfg.mouse_var);
      REG_STRETCH_VAR: prdata = 32'(cfg.stretch_var);
      REG_WALK_VAR:    prdata = 32'(cfg.walk_var);
      REG_IDLE_RNG:    prdata = 32'(cfg.idle_rng);
      REG_TYPING_RNG:  prdata = 32'(cfg.typing_rng);
      REG_STRETCH_RNG: prdata = 32'(cfg.stretch_rng);
      default:         prdata = '0;
    endcase
  end

  awac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  awac_dp #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .sample    (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_act   (act),
    .out_conf  (conf)
  );

  assign m_tdata = {6'b0, conf, act};

endmodule
`default_nettype wire

// ===== test/tb_accel_window_activity_classifier_unit.sv =====
// Self-checking bench for accel_window_activity_classifier_unit: drives sample and
// classify transactions, predicts activity and confidence, checks each result.
// Depends on awac_pkg and the RTL of the unit.
`timescale 1ns / 100ps
module tb_accel_window_activity_classifier_unit;
  import awac_pkg::*;

  localparam int WIN = WINDOW_DEF;

  typedef struct {
    logic [2:0] act;
    logic [6:0] conf;
  } label_t;

  // Window predictor and store of expected activity labels
  class activity_scoreboard;
    logic [16:0] mags[WIN];
    int unsigned wr_slot;
    bit filled;
    logic [6:0] last_conf;
    logic [31:0] thresh[NUM_REGS];
    label_t expected_labels[$];

    function new();
      wr_slot = 0;
      filled = 0;
      last_conf = CONF_RESET;
      thresh[REG_IDLE_VAR] = 32'(IDLE_VAR_RST);
      thresh[REG_TYPING_VAR] = 32'(TYPING_VAR_RST);
      thresh[REG_MOUSE_VAR] = 32'(MOUSE_VAR_RST);
      thresh[REG_STRETCH_VAR] = 32'(STRETCH_VAR_RST);
      thresh[REG_WALK_VAR] = 32'(WALK_VAR_RST);
      thresh[REG_IDLE_RNG] = 32'(IDLE_RNG_RST);
      thresh[REG_TYPING_RNG] = 32'(TYPING_RNG_RST);
      thresh[REG_STRETCH_RNG] = 32'(STRETCH_RNG_RST);
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      thresh[idx] = (idx < 5) ? (v & 32'h3FFF_FFFF) : (v & 32'h0000_FFFF);
    endfunction

    function longint unsigned magnitude(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] z);
      longint sx, sy, sz;
      longint unsigned n, root, t;
      sx = x; sy = y; sz = z;
      if (sx < 0) sx = -sx;
      if (sy < 0) sy = -sy;
      if (sz < 0) sz = -sz;
      n = sx * sx + sy * sy + sz * sz;
      root = 0;
      // Build the floor square root one bit at a time
      for (int b = 17; b >= 0; b--) begin
        t = root | (64'd1 << b);
        if (t * t <= n) root = t;
      end
      return root;
    endfunction

    function label_t classify_window();
      label_t r;
      longint unsigned sum, sq, var_q, d;
      logic [31:0] maxv, minv, rng;
      int unsigned steps;
      sum = 0; sq = 0; maxv = 0; minv = RANGE_MIN_START; steps = 0;
      for (int i = 0; i < WIN; i++) begin
        sum += mags[i];
        sq += longint'(mags[i]) * mags[i];
        if (mags[i] > maxv) maxv = mags[i];
        if (mags[i] < minv) minv = mags[i];
        if (i > 0) begin
          d = (mags[i] > mags[i-1]) ? mags[i] - mags[i-1] : mags[i-1] - mags[i];
          if (d > STEP_LIMIT) steps++;
        end
      end
      rng = maxv - minv;
      // Exact floor of sumsq/W - (sum/W)^2; the numerator is never negative
      var_q = (WIN * sq - sum * sum) / (WIN * WIN);
      if (var_q < thresh[REG_IDLE_VAR] && rng < thresh[REG_IDLE_RNG]) begin
        r.act = ACT_IDLE; r.conf = CONF_IDLE;
      end else if (var_q < thresh[REG_TYPING_VAR] && rng < thresh[REG_TYPING_RNG]) begin
        r.act = ACT_TYPING; r.conf = CONF_TYPING;
      end else if (var_q < thresh[REG_MOUSE_VAR] && steps > MOUSE_STEPS) begin
        r.act = ACT_MOUSE; r.conf = CONF_MOUSE;
      end else if (rng > thresh[REG_STRETCH_RNG] && var_q < thresh[REG_STRETCH_VAR]) begin
        r.act = ACT_STRETCH; r.conf = CONF_STRETCH;
      end else if (steps > WALK_STEPS && var_q > thresh[REG_WALK_VAR]) begin
        r.act = ACT_WALK; r.conf = CONF_WALK;
      end else if (var_q < thresh[REG_TYPING_VAR]) begin
        r.act = ACT_PHONE; r.conf = CONF_PHONE;
      end else begin
        r.act = ACT_IDLE; r.conf = CONF_OTHER;
      end
      return r;
    endfunction

    function void note_input(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
      label_t r;
      if (cmd == CMD_STORE) begin
        mags[wr_slot] = 17'(magnitude(x, y, z));
        wr_slot++;
        if (wr_slot >= WIN) begin
          wr_slot = 0;
          filled = 1;
        end
      end else if (!filled) begin
        r.act = ACT_IDLE;
        r.conf = last_conf;
        expected_labels.push_back(r);
      end else begin
        r = classify_window();
        last_conf = r.conf;
        expected_labels.push_back(r);
      end
    endfunction

    // 0 match, 1 nothing expected, 2 field mismatch
    function int check_result(logic [2:0] act, logic [6:0] conf, output label_t exp_l);
      exp_l.act = 0;
      exp_l.conf = 0;
      if (expected_labels.size() == 0) return 1;
      exp_l = expected_labels.pop_front();
      if (act !== exp_l.act || conf !== exp_l.conf) return 2;
      return 0;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // sample_x[15:0], sample_y[31:16], sample_z[47:32]
  logic        s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // activity[2:0], confidence[9:3]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  activity_scoreboard sb;
  int  errors;
  bit  quiet;
  bit  hold_req;
  int  amp, base, noise;
  bit  alt;

  accel_window_activity_classifier_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Two-phase register write
  task automatic apb_write(int idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx * 4); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Offer one transaction and hold until accepted
  task automatic send_item(logic cmd, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {z, y, x};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, x, y, z);
  endtask

  // Let every result arrive, then let a store still in work finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_labels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] clip(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // One sample shaped by the current profile, sometimes pure noise
  task automatic send_profiled_store();
    int x, y, z;
    if ($urandom_range(0, 9) == 0) begin
      send_item(CMD_STORE, 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      alt = ~alt;
      x = base + (alt ? amp : -amp) + $urandom_range(0, 2 * noise) - noise;
      y = $urandom_range(0, 2 * noise) - noise;
      z = $urandom_range(0, 2 * noise) - noise;
      if ($urandom_range(0, 1)) x = -x;
      send_item(CMD_STORE, clip(x), clip(y), clip(z));
    end
  endtask

  task automatic pick_profile();
    int amps[7] = '{0, 30, 150, 300, 700, 2500, 9000};
    amp = amps[$urandom_range(0, 6)];
    base = $urandom_range(0, 12000);
    noise = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 400);
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Result side: random stalls plus one long hold-off on request
  initial begin
    label_t e;
    int w, rc;
    forever begin
      w = quiet ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        w = 3000;
        hold_req = 0;
      end
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      rc = sb.check_result(m_tdata[2:0], m_tdata[9:3], e);
      if (rc == 1)
        report($sformatf("unexpected result act=%0d conf=%0d", m_tdata[2:0], m_tdata[9:3]));
      else if (rc == 2)
        report($sformatf("act=%0d conf=%0d, expected act=%0d conf=%0d",
                         m_tdata[2:0], m_tdata[9:3], e.act, e.conf));
    end
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [31:0] cfg[8];
    clk = 1'b0;
    sb = new();
    errors = 0;
    quiet = 0;
    hold_req = 0;
    alt = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0; s_tuser <= CMD_STORE; s_tdata <= '0;
    m_tready <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: classify on a partial window, then extreme samples
    send_item(CMD_CLASSIFY, 16'h0, 16'h0, 16'h0);
    send_item(CMD_STORE, 16'h8000, 16'h8000, 16'h8000);
    send_item(CMD_STORE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(CMD_STORE, 16'h0000, 16'h0000, 16'h0000);
    send_item(CMD_STORE, 16'hFFFF, 16'h0001, 16'h8000);
    send_item(CMD_STORE, 16'h7FFF, 16'h8000, 16'h0000);
    send_item(CMD_CLASSIFY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_STORE, 16'h1000, 16'h0000, 16'h0000);
    send_item(CMD_STORE, 16'h0000, 16'hF000, 16'h0000);
    send_item(CMD_CLASSIFY, 16'h0, 16'h0, 16'h0);

    // Phases: thresholds written while idle, then profiled traffic
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        1: cfg = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        2: cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
        4: cfg = '{1000, 20000, 400000, 3000000, 1000000, 30, 300, 100};
        5: cfg = '{$urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom};
        6: cfg = '{0, 0, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 0, 16'hFFFF, 16'hFFFF, 0};
        default: cfg = '{IDLE_VAR_RST, TYPING_VAR_RST, MOUSE_VAR_RST, STRETCH_VAR_RST,
                         WALK_VAR_RST, IDLE_RNG_RST, TYPING_RNG_RST, STRETCH_RNG_RST};
      endcase
      if (ph == 5)
        for (int i = 0; i < 5; i++) cfg[i] = $urandom_range(0, 6000000);
      for (int i = 0; i < NUM_REGS; i++) apb_write(i, cfg[i]);

      // Long result hold-off while classify transactions keep coming
      if (ph == 3) begin
        hold_req = 1;
        for (int i = 0; i < 6; i++) send_item(CMD_CLASSIFY, 16'h0, 16'h0, 16'h0);
      end

      for (int i = 0; i < 180; i++) begin
        if (i % 45 == 0) pick_profile();
        if ($urandom_range(0, 11) == 0)
          send_item(CMD_CLASSIFY, 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_profiled_store();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.expected_labels.size() != 0)
      report($sformatf("%0d results never arrived", sb.expected_labels.size()));
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
